// ----- src/nma_pkg.sv -----
// Shared types, constants and the sigmoid table generator of the neuron MAC core.
package nma_pkg;

	localparam int DATA_W = 16;
	localparam int FRAC_BITS = 12;
	localparam int PROD_W = 2 * DATA_W;
	localparam int ACC_W = 40;
	localparam int TOT_W = ACC_W + 1;
	localparam int SIG_DEPTH = 256;
	localparam int SIG_IDX_W = $clog2(SIG_DEPTH);
	localparam int ROM_W = FRAC_BITS + 1;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BIAS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXCIT = 2'd2;

	localparam longint Q30_ONE = 64'sd1 <<< 30;

	typedef enum logic {
		MODE_LINEAR = 1'b0,
		MODE_LOGISTIC = 1'b1
	} act_mode_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] bias;
		act_mode_t mode;
		logic excit;
	} nma_cfg_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] prod;
		logic last;
	} nma_entry_t;

	// Restoring division of a nonnegative dividend below 2^48 by a positive divisor.
	function automatic longint udiv(input longint a, input longint b);
		longint q;
		longint r;
		int i;
		q = 64'sd0;
		r = 64'sd0;
		for (i = 47; i >= 0; i--) begin
			r = (r <<< 1) | ((a >>> i) & 64'sd1);
			if (r >= b) begin
				r = r - b;
				q = q | (64'sd1 <<< i);
			end
		end
		return q;
	endfunction

	// Entry idx holds the rounded sigmoid at the center of bin idx of [-8,8),
	// built from a Q30 series for exp followed by three squarings.
	function automatic logic [ROM_W-1:0] sigmoid_entry(input int idx);
		longint c;
		longint k;
		longint term;
		longint acc;
		longint p;
		longint den;
		longint num;
		longint v;
		int n;
		c = longint'(2 * idx + 1 - SIG_DEPTH);
		k = (c < 0) ? -c : c;
		term = Q30_ONE;
		acc = Q30_ONE;
		for (n = 1; n < 26; n++) begin
			term = udiv(term * k, longint'(SIG_DEPTH) * longint'(n));
			if (n[0])
				acc = acc - term;
			else
				acc = acc + term;
		end
		p = (acc < 0) ? 64'sd0 : acc;
		for (n = 0; n < 3; n++) begin
			p = (p * p + (64'sd1 <<< 29)) >>> 30;
		end
		den = Q30_ONE + p;
		num = (c >= 0) ? Q30_ONE : p;
		v = udiv((num <<< FRAC_BITS) + (den >>> 1), den);
		return v[ROM_W-1:0];
	endfunction

endpackage

// ----- src/nma_front.sv -----
// Front end: takes synapse transactions, forms the product and marks the last one.
module nma_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [31:0]         s_axis_tdata,  // signal[15:0], weight[31:16]
	input  logic                s_axis_tlast,  // last
	input  logic                q_full,
	output logic                q_push,
	output nma_pkg::nma_entry_t q_entry
);
	import nma_pkg::*;

	logic                     vld_s1;
	logic signed [DATA_W-1:0] sig_s1;
	logic signed [DATA_W-1:0] wt_s1;
	logic                     last_s1;

	assign q_push = vld_s1 && !q_full;
	assign s_axis_tready = !vld_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			sig_s1 <= s_axis_tdata[DATA_W-1:0];
			wt_s1 <= s_axis_tdata[2*DATA_W-1:DATA_W];
			last_s1 <= s_axis_tlast;
		end
	end

	always_comb begin
		q_entry.prod = sig_s1 * wt_s1;
		q_entry.last = last_s1;
	end

endmodule

// ----- src/nma_queue.sv -----
// Short queue of product entries between the front and back ends.
module nma_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  nma_pkg::nma_entry_t wr_entry,
	output logic                full,
	output logic                valid,
	output nma_pkg::nma_entry_t rd_entry,
	input  logic                pop
);
	import nma_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	nma_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == FULL_CNT);
	assign valid = (count_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_CNT)
		else $error("queue count exceeds its depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");

endmodule

// ----- src/nma_back.sv -----
// Back end: accumulates products, applies bias and activation, and holds the result.
module nma_back (
	input  logic                clk,
	input  logic                arst_n,
	input  nma_pkg::nma_cfg_t   cfg,
	input  logic                q_valid,
	input  nma_pkg::nma_entry_t q_entry,
	output logic                q_pop,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [31:0]         m_axis_tdata  // activation_out[15:0], outgoing_signal[31:16]
);
	import nma_pkg::*;

	localparam int LIN_W = TOT_W + 1;
	localparam int LOG_W = TOT_W + 4;
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};
	localparam logic signed [DATA_W-1:0] OUT_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
	localparam logic signed [DATA_W-1:0] OUT_MIN = {1'b1, {(DATA_W - 1){1'b0}}};
	localparam logic signed [LIN_W-1:0] LIN_HALF = LIN_W'(2 ** (FRAC_BITS - 1));
	localparam logic signed [LIN_W-1:0] LIN_MAX = LIN_W'(2 ** (DATA_W - 1) - 1);
	localparam logic signed [LIN_W-1:0] LIN_MIN = -LIN_W'(2 ** (DATA_W - 1));
	localparam logic signed [LOG_W-1:0] LOG_OFS =
		LOG_W'(2 ** (2 * FRAC_BITS + 2) - 2 ** (FRAC_BITS - 1));
	localparam logic signed [LOG_W-1:0] X_MAX = LOG_W'((8 << FRAC_BITS) - 1);
	localparam logic signed [LOG_W-1:0] X_MIN = -LOG_W'(8 << FRAC_BITS);
	localparam logic [DATA_W-1:0] SIGN_BIT = {1'b1, {(DATA_W - 1){1'b0}}};

	logic adv;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W:0]   add_c;
	logic signed [ACC_W-1:0] sum_c;

	logic                    vld_s2;
	logic signed [ACC_W-1:0] fin_s2;
	logic                    vld_s3;
	logic signed [TOT_W-1:0] tot_s3;
	logic                    vld_s4;
	logic signed [DATA_W-1:0] lin_s4;
	logic [SIG_IDX_W-1:0]    idx_s4;

	logic signed [LIN_W-1:0] lin_c;
	logic signed [DATA_W-1:0] lin_sat_c;
	logic signed [LOG_W-1:0] log_c;
	logic signed [LOG_W-1:0] x_c;
	logic [DATA_W-1:0]       xu_c;

	logic [ROM_W-1:0]        rom [SIG_DEPTH];
	logic signed [DATA_W-1:0] act_c;
	logic signed [DATA_W-1:0] outg_c;

	logic                    out_vld_q;
	logic signed [DATA_W-1:0] act_q;
	logic signed [DATA_W-1:0] outg_q;

	for (genvar g = 0; g < SIG_DEPTH; g++) begin : g_rom
		localparam logic [ROM_W-1:0] ROM_VAL = sigmoid_entry(g);
		assign rom[g] = ROM_VAL;
	end

	assign adv = !out_vld_q || m_axis_tready;
	assign q_pop = q_valid && adv;

	// Accumulate with saturation at the accumulator limits.
	always_comb begin
		add_c = {acc_q[ACC_W-1], acc_q}
			+ {{(ACC_W + 1 - PROD_W){q_entry.prod[PROD_W-1]}}, q_entry.prod};
		if (add_c[ACC_W] != add_c[ACC_W-1])
			sum_c = add_c[ACC_W] ? ACC_MIN : ACC_MAX;
		else
			sum_c = add_c[ACC_W-1:0];
	end

	// Linear rounding and the scaled logistic argument, both rounded half up.
	always_comb begin
		lin_c = ($signed({tot_s3[TOT_W-1], tot_s3}) + LIN_HALF) >>> FRAC_BITS;
		if (lin_c > LIN_MAX)
			lin_sat_c = OUT_MAX;
		else if (lin_c < LIN_MIN)
			lin_sat_c = OUT_MIN;
		else
			lin_sat_c = lin_c[DATA_W-1:0];

		log_c = ($signed({tot_s3[TOT_W-1], tot_s3, 3'b000}) - LOG_OFS) >>> FRAC_BITS;
		if (log_c > X_MAX)
			x_c = X_MAX;
		else if (log_c < X_MIN)
			x_c = X_MIN;
		else
			x_c = log_c;
		xu_c = x_c[DATA_W-1:0] ^ SIGN_BIT;
	end

	always_comb begin
		if (cfg.mode == MODE_LOGISTIC)
			act_c = {{(DATA_W - ROM_W){1'b0}}, rom[idx_s4]};
		else
			act_c = lin_s4;
		if (cfg.excit)
			outg_c = act_c;
		else
			outg_c = (act_c == OUT_MIN) ? OUT_MAX : -act_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			if (q_pop)
				acc_q <= q_entry.last ? '0 : sum_c;
			vld_s2 <= q_pop && q_entry.last;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			out_vld_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fin_s2 <= sum_c;
			tot_s3 <= TOT_W'(fin_s2) + (TOT_W'(cfg.bias) <<< FRAC_BITS);
			lin_s4 <= lin_sat_c;
			idx_s4 <= xu_c[DATA_W-1 -: SIG_IDX_W];
			act_q <= act_c;
			outg_q <= outg_c;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = {outg_q, act_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_entry.last |=> acc_q == '0)
		else $error("sum not cleared after the last synapse");

	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({vld_s2, vld_s3, vld_s4}))
		else $error("pipeline moved while the output was stalled");

endmodule

// ----- src/neuron_mac_activation_core.sv -----
// Top level of the neuron multiply-accumulate and activation core.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: signal[15:0], weight[31:16]; tlast: last
//  m_axis    out        tdata: activation_out[15:0], outgoing_signal[31:16]
//  cfg       in         cfg_index 0 bias, 1 activation_mode, 2 excitatory
//
// Unless the output stalls, one synapse transaction is taken per cycle; the rate
// is set by the single accumulate stage, which adds one product to the 40-bit sum
// each cycle. A result passes stages s2, s3 and s4, then the output register.
// Reset clears the sum, the queue and all valid flags; no clearing pass.
// A stalled output stops the back end; the queue then fills and the input stalls.
module neuron_mac_activation_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [31:0]                    s_axis_tdata,  // signal[15:0], weight[31:16]
	input  logic                           s_axis_tlast,  // last
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [31:0]                    m_axis_tdata,  // activation_out[15:0], outgoing_signal[31:16]
	input  logic                           cfg_we,
	input  logic [nma_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nma_pkg::DATA_W-1:0]     cfg_wdata
);
	import nma_pkg::*;

	nma_cfg_t   cfg_q;
	logic       q_push;
	logic       q_full;
	logic       q_valid;
	logic       q_pop;
	nma_entry_t wr_entry;
	nma_entry_t rd_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bias <= '0;
			cfg_q.mode <= MODE_LINEAR;
			cfg_q.excit <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BIAS: cfg_q.bias <= cfg_wdata;
				REG_MODE: cfg_q.mode <= act_mode_t'(cfg_wdata[0]);
				REG_EXCIT: cfg_q.excit <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	nma_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_entry       (wr_entry)
	);

	nma_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (wr_entry),
		.full     (q_full),
		.valid    (q_valid),
		.rd_entry (rd_entry),
		.pop      (q_pop)
	);

	nma_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_entry       (rd_entry),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
